@@ src/assert_macros.svh @@
// assertion macros shared by the truncated mean block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(LBL, CK, RS, PROP, MSG) \
  LBL: assert property (@(posedge CK) disable iff (RS) (PROP)) else $error(MSG);
`define ASSERT_IMPLY(LBL, CK, RS, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CK) disable iff (RS) (ANTE) |-> (CONS)) else $error(MSG);
`define ASSERT_NEXT(LBL, CK, RS, ANTE, CONS, MSG) \
  LBL: assert property (@(posedge CK) disable iff (RS) (ANTE) |=> (CONS)) else $error(MSG);
`else
`define ASSERT_ALWAYS(LBL, CK, RS, PROP, MSG)
`define ASSERT_IMPLY(LBL, CK, RS, ANTE, CONS, MSG)
`define ASSERT_NEXT(LBL, CK, RS, ANTE, CONS, MSG)
`endif
`endif

@@ src/tmsw_pkg.sv @@
// shared types and constants of the truncated mean block
package tmsw_pkg;

  localparam int MAX_HITS_DEFAULT = 64;
  localparam int SAMPLE_W         = 16;
  localparam int FRAC_W           = 11;
  localparam int FRAC_SHIFT       = 10;
  localparam int MEAN_W           = 24;
  localparam int MEAN_FRAC_BITS   = 8;
  localparam int FIFO_DEPTH       = 4;

  localparam logic [FRAC_W-1:0] UPPER_RESET = 11'd768;
  localparam logic [FRAC_W-1:0] LOWER_RESET = 11'd51;
  localparam logic [FRAC_W-1:0] ROUND_HALF  = 11'd512;

  localparam logic [0:0] REG_UPPER = 1'b0;
  localparam logic [0:0] REG_LOWER = 1'b1;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                last;
    logic                keep;
    logic                ovf;
  } queue_entry_t;

  typedef struct packed {
    logic         push;
    queue_entry_t entry;
  } fifo_push_t;

  typedef struct packed {
    logic         avail;
    queue_entry_t entry;
  } fifo_head_t;

endpackage

@@ src/tmsw_front.sv @@
// front end: accepts samples, counts the set and marks dropped samples
module tmsw_front #(
  parameter int MAX_HITS = tmsw_pkg::MAX_HITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic [tmsw_pkg::SAMPLE_W-1:0]  sample,
  input  logic                           last,
  input  logic                           fifo_full,
  output tmsw_pkg::fifo_push_t           push
);
  import tmsw_pkg::*;

  localparam int CW = $clog2(MAX_HITS + 1);

  logic [CW-1:0] count;
  logic          dropped;
  logic          keep;
  logic          accept;

  assign sample_stall = fifo_full;
  assign accept       = sample_valid && !fifo_full;
  assign keep         = count < CW'(MAX_HITS);

  assign push.push         = accept;
  assign push.entry.sample = sample;
  assign push.entry.last   = last;
  assign push.entry.keep   = keep;
  assign push.entry.ovf    = dropped || !keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      dropped <= 1'b0;
    end else if (accept) begin
      if (last) begin
        count   <= '0;
        dropped <= 1'b0;
      end else if (keep) begin
        count <= count + 1'b1;
      end else begin
        dropped <= 1'b1;
      end
    end
  end

endmodule

@@ src/tmsw_fifo.sv @@
// short request queue between the front end and the back end
module tmsw_fifo (
  input  logic                 clk,
  input  logic                 rst,
  input  tmsw_pkg::fifo_push_t push,
  input  logic                 pop,
  output logic                 full,
  output tmsw_pkg::fifo_head_t head
);
  import tmsw_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int LW = $clog2(FIFO_DEPTH + 1);

  queue_entry_t  entries [FIFO_DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [LW-1:0] level;
  logic          do_push;

  assign full       = level == LW'(FIFO_DEPTH);
  assign do_push    = push.push && !full;
  assign head.avail = level != '0;
  assign head.entry = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, pop})
        2'b10:   level <= level + 1'b1;
        2'b01:   level <= level - 1'b1;
        default: level <= level;
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_level_cap, clk, rst, level <= LW'(FIFO_DEPTH), "queue level above depth")
  `ASSERT_IMPLY(a_pop_nonempty, clk, rst, pop, level != '0, "pop from empty queue")

endmodule

@@ src/tmsw_back.sv @@
// back end: sorted insertion chain, rank window sum and serial divide
module tmsw_back #(
  parameter int MAX_HITS = tmsw_pkg::MAX_HITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [tmsw_pkg::FRAC_W-1:0]   upper_fraction_q10,
  input  logic [tmsw_pkg::FRAC_W-1:0]   lower_fraction_q10,
  input  tmsw_pkg::fifo_head_t          head,
  output logic                          pop,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [tmsw_pkg::MEAN_W-1:0]   mean_q8,
  output logic                          valid_res,
  output logic                          overflow
);
  import tmsw_pkg::*;

  localparam int CW  = $clog2(MAX_HITS + 1);
  localparam int RW  = CW + 1;
  localparam int DVW = CW + 2;
  localparam int PW  = CW + FRAC_W + 1;
  localparam int SW  = SAMPLE_W + CW;
  localparam int NW  = SW + MEAN_FRAC_BITS;
  localparam int QCW = $clog2(NW + 1);

  typedef enum logic [2:0] {
    S_LOAD,
    S_MUL,
    S_SETUP,
    S_SUM,
    S_DIV,
    S_OUT
  } state_t;

  state_t state;

  logic [SAMPLE_W-1:0] cells      [MAX_HITS];
  logic [SAMPLE_W-1:0] cells_next [MAX_HITS];
  logic [SAMPLE_W-1:0] prev_cell  [MAX_HITS];
  logic [MAX_HITS-1:0] gt;
  logic [MAX_HITS-1:0] prev_gt;

  logic [CW-1:0]  count;
  logic           ovf_set;
  logic [RW-1:0]  up_rank;
  logic [RW-1:0]  lo_rank;
  logic [RW-1:0]  first_rank;
  logic [RW-1:0]  stop_rank;
  logic [RW-1:0]  rank;
  logic [DVW-1:0] divisor;
  logic [SW-1:0]  sum;
  logic [DVW-1:0] rem;
  logic [NW-1:0]  quo;
  logic [QCW-1:0] step;

  logic           insert_en;
  logic           shift_en;
  logic [PW-1:0]  prod_up;
  logic [PW-1:0]  prod_lo;
  logic signed [DVW:0] d_signed;
  logic           d_pos;
  logic [RW-1:0]  count_ext;
  logic [DVW:0]   trial;
  logic           fits;
  logic [DVW-1:0] rem_next;
  logic [NW-1:0]  quo_next;

  assign pop          = (state == S_LOAD) && head.avail;
  assign insert_en    = pop && head.entry.keep;
  assign count_ext    = RW'(count);
  assign shift_en     = (state == S_SUM) && (rank <= count_ext);
  assign result_valid = state == S_OUT;

  // rank arithmetic
  assign prod_up  = PW'(count) * PW'(upper_fraction_q10);
  assign prod_lo  = PW'(count) * PW'(lower_fraction_q10) + PW'(ROUND_HALF);
  assign d_signed = $signed({2'b00, up_rank}) - $signed({2'b00, lo_rank})
                    + $signed((DVW+1)'(1));
  assign d_pos    = !d_signed[DVW] && (d_signed != '0);

  // restoring divide, one quotient bit a cycle
  assign trial    = {rem, quo[NW-1]};
  assign fits     = trial >= {1'b0, divisor};
  assign rem_next = fits ? DVW'(trial - {1'b0, divisor}) : trial[DVW-1:0];
  assign quo_next = {quo[NW-2:0], fits};

  // insertion chain: cells above the insert point move up one place
  always_comb begin
    prev_gt[0]   = 1'b0;
    prev_cell[0] = cells[0];
    for (int i = 0; i < MAX_HITS; i++) begin
      gt[i] = (CW'(i) < count) && (cells[i] > head.entry.sample);
    end
    for (int i = 1; i < MAX_HITS; i++) begin
      prev_gt[i]   = gt[i-1];
      prev_cell[i] = cells[i-1];
    end
    for (int i = 0; i < MAX_HITS; i++) begin
      if (prev_gt[i]) begin
        cells_next[i] = prev_cell[i];
      end else if (gt[i] || (CW'(i) == count)) begin
        cells_next[i] = head.entry.sample;
      end else begin
        cells_next[i] = cells[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (insert_en) begin
      cells <= cells_next;
    end else if (shift_en) begin
      for (int i = 0; i < MAX_HITS - 1; i++) begin
        cells[i] <= cells[i+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      count <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (pop) begin
            if (head.entry.keep) begin
              count <= count + 1'b1;
            end
            if (head.entry.last) begin
              ovf_set <= head.entry.ovf;
              state   <= S_MUL;
            end
          end
        end
        S_MUL: begin
          up_rank <= RW'(prod_up >> FRAC_SHIFT);
          lo_rank <= RW'(prod_lo >> FRAC_SHIFT);
          state   <= S_SETUP;
        end
        S_SETUP: begin
          first_rank <= (lo_rank == '0) ? RW'(1) : lo_rank;
          stop_rank  <= (up_rank < count_ext) ? up_rank : count_ext;
          divisor    <= d_signed[DVW-1:0];
          sum        <= '0;
          rank       <= RW'(1);
          if (d_pos) begin
            state <= S_SUM;
          end else begin
            count     <= '0;
            mean_q8   <= '0;
            valid_res <= 1'b0;
            overflow  <= ovf_set;
            state     <= S_OUT;
          end
        end
        S_SUM: begin
          // the chain shifts down, so cell 0 holds the sample of this rank
          if (rank <= count_ext) begin
            if ((rank >= first_rank) && (rank <= stop_rank)) begin
              sum <= sum + SW'(cells[0]);
            end
            rank <= rank + 1'b1;
          end else begin
            count <= '0;
            rem   <= '0;
            quo   <= {sum, {MEAN_FRAC_BITS{1'b0}}};
            step  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem  <= rem_next;
          quo  <= quo_next;
          step <= step + 1'b1;
          if (step == QCW'(NW - 1)) begin
            mean_q8   <= quo_next[MEAN_W-1:0];
            valid_res <= 1'b1;
            overflow  <= ovf_set;
            state     <= S_OUT;
          end
        end
        S_OUT: begin
          if (!result_stall) begin
            state <= S_LOAD;
          end
        end
        default: begin
          state <= S_LOAD;
        end
      endcase
    end
  end

`include "assert_macros.svh"

  `ASSERT_ALWAYS(a_count_cap, clk, rst, count <= CW'(MAX_HITS), "sample count above capacity")
  `ASSERT_IMPLY(a_div_nonzero, clk, rst, state == S_DIV, divisor != '0, "divide by zero")
  `ASSERT_IMPLY(a_out_cleared, clk, rst, state == S_OUT, count == '0, "set not cleared at result")
  `ASSERT_NEXT(a_last_closes, clk, rst, pop && head.entry.last, state == S_MUL, "last missed")

endmodule

@@ src/truncated_mean_sorted_window.sv @@
// Truncated mean of a sorted window of pulse-height samples.
// Sample channel: sample and last with sample_valid/sample_stall; a request is
// taken when sample_valid is high and sample_stall low. last closes the set.
// Result channel: mean_q8, valid_res and overflow with result_valid and
// result_stall; one result per set, held until taken.
// Configuration: cfg_write with cfg_index (0 upper, 1 lower fraction) and
// cfg_data, written while the block is idle; the block itself does not enforce this.
// The front end accepts one sample a cycle, unless the queue is full, into a
// 4-deep queue; the back end pops one a cycle while loading, if the queue holds
// an entry, into a sorted insertion chain. After the last sample the back end
// works out the ranks (S_MUL, S_SETUP), sums the chain over the stored count and
// runs the serial divider, then presents the result. While the back end works
// or the result waits, the queue fills and then sample_stall rises; the next set
// is otherwise taken at one sample a cycle.
// A set with a divisor that is not positive skips sum and divide and returns
// valid_res low. Reset empties the queue and the set and restores the
// fraction registers to 768 and 51.
module truncated_mean_sorted_window #(
  parameter int MAX_HITS = tmsw_pkg::MAX_HITS_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [0:0]                     cfg_index,
  input  logic [tmsw_pkg::FRAC_W-1:0]    cfg_data,
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  logic [tmsw_pkg::SAMPLE_W-1:0]  sample,
  input  logic                           last,
  output logic                           result_valid,
  input  logic                           result_stall,
  output logic [tmsw_pkg::MEAN_W-1:0]    mean_q8,
  output logic                           valid_res,
  output logic                           overflow
);
  import tmsw_pkg::*;

  logic [FRAC_W-1:0] upper_fraction_q10;
  logic [FRAC_W-1:0] lower_fraction_q10;
  fifo_push_t        push;
  fifo_head_t        head;
  logic              fifo_full;
  logic              pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      upper_fraction_q10 <= UPPER_RESET;
      lower_fraction_q10 <= LOWER_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_UPPER: upper_fraction_q10 <= cfg_data;
        REG_LOWER: lower_fraction_q10 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  tmsw_front #(.MAX_HITS(MAX_HITS)) u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .last         (last),
    .fifo_full    (fifo_full),
    .push         (push)
  );

  tmsw_fifo u_fifo (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .full (fifo_full),
    .head (head)
  );

  tmsw_back #(.MAX_HITS(MAX_HITS)) u_back (
    .clk                (clk),
    .rst                (rst),
    .upper_fraction_q10 (upper_fraction_q10),
    .lower_fraction_q10 (lower_fraction_q10),
    .head               (head),
    .pop                (pop),
    .result_valid       (result_valid),
    .result_stall       (result_stall),
    .mean_q8            (mean_q8),
    .valid_res          (valid_res),
    .overflow           (overflow)
  );

endmodule

@@ tb/truncated_mean_sorted_window_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for the truncated mean block with its own mean predictor
module truncated_mean_sorted_window_tb;
  import tmsw_pkg::*;

  localparam int HITS           = MAX_HITS_DEFAULT;
  localparam int RANDOM_ITEMS   = 1400;
  localparam int CFG_SETTLE     = 150;
  localparam int RX_HOLD        = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int IDLE_PCT       = 17;

  typedef struct packed {
    logic [MEAN_W-1:0] mean;
    logic              ok;
    logic              ovf;
  } mean_res_t;

  typedef enum logic {ROW_SAMPLE, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t          kind;
    logic [0:0]         reg_idx;
    logic [15:0]        value;
    logic               close;
    bit                 typed;
    mean_res_t          known;
  } script_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_write;
  logic [0:0]          cfg_index;
  logic [FRAC_W-1:0]   cfg_data;
  logic                sample_valid;
  logic                sample_stall;
  logic [SAMPLE_W-1:0] sample;
  logic                last;
  logic                result_valid;
  logic                result_stall;
  logic [MEAN_W-1:0]   mean_q8;
  logic                valid_res;
  logic                overflow;

  truncated_mean_sorted_window #(.MAX_HITS(HITS)) dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .last         (last),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .mean_q8      (mean_q8),
    .valid_res    (valid_res),
    .overflow     (overflow)
  );

  always #4 clk = ~clk;

  // predictor state
  logic [SAMPLE_W-1:0] sorted_heights[$];
  logic                heights_dropped;
  logic [FRAC_W-1:0]   upper_frac;
  logic [FRAC_W-1:0]   lower_frac;
  mean_res_t           means_awaited[$];

  int mismatches;
  bit quiet;
  bit hold_request;

  // directed script: 768/51 after reset, then corner settings of both fractions
  script_row_t directed_rows [26] = '{
    '{ROW_SAMPLE, REG_UPPER, 16'd65535, 1'b1, 1'b1, '{24'd0, 1'b1, 1'b0}},
    '{ROW_SAMPLE, REG_UPPER, 16'd0,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd65535, 1'b1, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd65535, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd0,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd32768, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd1,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd65535, 1'b1, 1'b0, '0},
    '{ROW_CFG,    REG_UPPER, 16'd0,     1'b0, 1'b0, '0},
    '{ROW_CFG,    REG_LOWER, 16'd1024,  1'b0, 1'b0, '0},
    // divisor of zero
    '{ROW_SAMPLE, REG_UPPER, 16'd7,     1'b1, 1'b1, '{24'd0, 1'b0, 1'b0}},
    '{ROW_CFG,    REG_UPPER, 16'd1024,  1'b0, 1'b0, '0},
    '{ROW_CFG,    REG_LOWER, 16'd0,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd65535, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd65535, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd65535, 1'b0, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd65535, 1'b1, 1'b0, '0},
    // upper rank past the stored count
    '{ROW_CFG,    REG_UPPER, 16'd2047,  1'b0, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd100,   1'b0, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd300,   1'b0, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd200,   1'b1, 1'b0, '0},
    '{ROW_CFG,    REG_LOWER, 16'd2047,  1'b0, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd5,     1'b0, 1'b0, '0},
    '{ROW_SAMPLE, REG_UPPER, 16'd9,     1'b1, 1'b1, '{24'd0, 1'b0, 1'b0}},
    '{ROW_CFG,    REG_UPPER, 16'd768,   1'b0, 1'b0, '0},
    '{ROW_CFG,    REG_LOWER, 16'd51,    1'b0, 1'b0, '0}
  };

  // insert one height into the window; on close, work out the truncated mean
  function automatic bit absorb_height(input logic [SAMPLE_W-1:0] h, input logic close,
                                       output mean_res_t res);
    int n;
    int pos;
    int hi_rank;
    int lo_rank;
    int divisor;
    int first_r;
    int stop_r;
    longint unsigned total;
    res = '0;
    if (sorted_heights.size() < HITS) begin
      pos = sorted_heights.size();
      while (pos > 0 && sorted_heights[pos-1] > h) pos--;
      sorted_heights.insert(pos, h);
    end else begin
      heights_dropped = 1'b1;
    end
    if (!close) return 1'b0;
    n = sorted_heights.size();
    hi_rank = (n * int'(upper_frac)) / 1024;
    lo_rank = (n * int'(lower_frac) + 512) / 1024;
    divisor = hi_rank - lo_rank + 1;
    if (divisor > 0) begin
      first_r = (lo_rank < 1) ? 1 : lo_rank;
      stop_r  = (hi_rank < n) ? hi_rank : n;
      total = 0;
      for (int r = first_r; r <= stop_r; r++) total += sorted_heights[r-1];
      res.mean = MEAN_W'((total * 256) / longint'(divisor));
      res.ok   = 1'b1;
    end
    res.ovf = heights_dropped;
    sorted_heights.delete();
    heights_dropped = 1'b0;
    return 1'b1;
  endfunction

  task automatic send_height(input logic [SAMPLE_W-1:0] h, input logic close,
                             input bit typed, input mean_res_t known);
    mean_res_t res;
    while (!quiet && $urandom_range(99) < IDLE_PCT) begin
      @(negedge clk);
      sample_valid <= 1'b0;
    end
    @(negedge clk);
    sample_valid <= 1'b1;
    sample       <= h;
    last         <= close;
    @(posedge clk);
    while (sample_stall) @(posedge clk);
    if (absorb_height(h, close, res))
      means_awaited.insert(means_awaited.size(), typed ? known : res);
  endtask

  // drop the request and wait until the block has drained
  task automatic settle_idle();
    @(negedge clk);
    sample_valid <= 1'b0;
    while (means_awaited.size() != 0) @(posedge clk);
    repeat (CFG_SETTLE) @(posedge clk);
  endtask

  task automatic write_fraction(input logic [0:0] idx, input logic [FRAC_W-1:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_UPPER) upper_frac = val;
    else lower_frac = val;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_height();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return SAMPLE_W'($urandom_range(0, 15));
      3:       return 16'hFFFF - SAMPLE_W'($urandom_range(0, 15));
      default: return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic int pick_set_len();
    int r;
    r = $urandom_range(0, 24);
    if (r == 0) return $urandom_range(HITS - 4, HITS + 8);
    if (r < 4) return 1;
    return $urandom_range(2, 24);
  endfunction

  // stimulus
  initial begin : stimulus
    logic [FRAC_W-1:0] corner_upper [8] = '{11'd0, 11'd1024, 11'd2047, 11'd768,
                                            11'd1024, 11'd2047, 11'd1, 11'd1536};
    logic [FRAC_W-1:0] corner_lower [8] = '{11'd0, 11'd1024, 11'd2047, 11'd51,
                                            11'd0, 11'd0, 11'd512, 11'd102};
    logic [FRAC_W-1:0] up_val;
    logic [FRAC_W-1:0] lo_val;
    int items_sent;
    int phase;
    int phase_items;
    int len;
    rst          = 1'b1;
    cfg_write    = 1'b0;
    cfg_index    = REG_UPPER;
    cfg_data     = '0;
    sample_valid = 1'b0;
    sample       = '0;
    last         = 1'b0;
    quiet        = 1'b0;
    hold_request = 1'b0;
    mismatches   = 0;
    upper_frac   = UPPER_RESET;
    lower_frac   = LOWER_RESET;
    heights_dropped = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        settle_idle();
        write_fraction(directed_rows[i].reg_idx, FRAC_W'(directed_rows[i].value));
      end else begin
        send_height(directed_rows[i].value, directed_rows[i].close,
                    directed_rows[i].typed, directed_rows[i].known);
      end
    end

    items_sent = 0;
    phase = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if (phase < 8) begin
        up_val = corner_upper[phase];
        lo_val = corner_lower[phase];
      end else begin
        up_val = FRAC_W'($urandom_range(0, 2047));
        lo_val = ($urandom_range(0, 3) == 0) ? FRAC_W'($urandom_range(0, 2047))
                                             : FRAC_W'($urandom_range(0, 300));
      end
      settle_idle();
      write_fraction(REG_UPPER, up_val);
      write_fraction(REG_LOWER, lo_val);
      quiet = (phase == 2);
      // receiver holds off while requests keep coming, so the input backs up
      if (phase == 4) hold_request = 1'b1;
      phase_items = 0;
      while (phase_items < 110) begin
        len = pick_set_len();
        for (int k = 0; k < len; k++) begin
          send_height(pick_height(), k == len - 1, 1'b0, '0);
        end
        phase_items += len;
        if ($urandom_range(0, 14) == 0) settle_idle();
      end
      items_sent += phase_items;
      phase++;
    end
    quiet = 1'b0;

    settle_idle();
    if (mismatches == 0 && means_awaited.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side: random stall, one long hold-off on request
  initial begin : result_side
    int hold_left;
    mean_res_t want;
    hold_left = 0;
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left = RX_HOLD;
      end
      result_stall <= (hold_left > 0) || (!quiet && $urandom_range(99) < IDLE_PCT);
      @(posedge clk);
      if (!rst && result_valid && !result_stall) begin
        if (means_awaited.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result: mean_q8=%0d valid_res=%0b overflow=%0b",
                     mean_q8, valid_res, overflow);
          mismatches++;
        end else begin
          want = means_awaited.pop_front();
          if (mean_q8 !== want.mean || valid_res !== want.ok || overflow !== want.ovf) begin
            if (mismatches < 10)
              $display("mean mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                       want.mean, want.ok, want.ovf, mean_q8, valid_res, overflow);
            mismatches++;
          end
        end
      end
    end
  end

  // no request moving on either channel for too long
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (sample_valid && !sample_stall) || (result_valid && !result_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TB_ERROR");
    $finish;
  end

endmodule
